/* rtl/linear_range_remap_defines.svh */
// ----------------------------------------------------------------------------
// Linear range remap assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_RANGE_REMAP_DEFINES_SVH
`define LINEAR_RANGE_REMAP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lrr_pkg.sv */
// ----------------------------------------------------------------------------
// Linear range remap package
// Widths, register indexes, saturation bounds and the result type.
// ----------------------------------------------------------------------------
package lrr_pkg;

  // Signed range the result is saturated to before limiting.
  localparam int unsigned DATA_WIDTH = 32;

  // Field and datapath widths.
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIFF_W    = WORD_W + 1;
  localparam int unsigned PROD_W    = 2 * WORD_W;
  localparam int unsigned DIVD_W    = PROD_W + 1;
  localparam int unsigned QUOT_W    = DIVD_W - WORD_W;
  localparam int unsigned DIV_STEPS = QUOT_W;
  localparam int unsigned SUM_W     = QUOT_W + 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLE = 3'd4;

  // Saturation bounds of the signed DATA_WIDTH range, at the sum width.
  localparam logic signed [SUM_W-1:0] SAT_MAX =
    SUM_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic [WORD_W-1:0] mapped;
    logic              err;
    logic              clamped;
  } result_t;

endpackage

/* rtl/linear_range_remap.sv */
// ----------------------------------------------------------------------------
// Linear range remap
// Pipelined linear mapping of a signed sample between two configured ranges.
// ----------------------------------------------------------------------------

// The block accepts one sample per clock cycle while in_stall_o is low and
// returns one result per sample, in order. The divider retires one quotient
// bit per pipeline stage over 33 stages; the input difference, the sign and
// magnitude split, the 32 by 32 bit multiply, the rounding offset, the sign
// restore and the saturate and limit step take one stage each. The mapped
// value is round((sample - input_low) * (output_high - output_low) /
// (input_high - input_low)) + output_low, with the half-range offset added
// before a division that truncates toward zero. The result is saturated to
// the signed DATA_WIDTH range and, with limit_enable set, clamped to the
// output range in whichever direction it runs. An empty input range returns
// output_low with range_error set. Registers may only be written while no
// transaction is in flight; the derived range terms settle in the cycle after
// a write.

`include "linear_range_remap_defines.svh"

module linear_range_remap (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Sample input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lrr_pkg::WORD_W-1:0]   sample_in_i,
  // Result output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [lrr_pkg::WORD_W-1:0]   mapped_out_o,
  output logic                                range_error_o,
  output logic                                was_clamped_o,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lrr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lrr_pkg::WORD_W-1:0]          cfg_data_i
);

  // Pipeline stage positions: sample, difference, magnitudes, product,
  // dividend, the divider steps, signed sum and the saturate/limit stage.
  localparam int unsigned ST_Y = 5 + lrr_pkg::DIV_STEPS;
  localparam int unsigned ST_R = ST_Y + 1;
  localparam int unsigned NST  = ST_R + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [lrr_pkg::WORD_W-1:0] in_low_q, in_high_q, out_low_q, out_high_q;
  logic                              lim_en_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_low_q   <= '0;
      in_high_q  <= 32'sd1000;
      out_low_q  <= '0;
      out_high_q <= 32'sd1000;
      lim_en_q   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lrr_pkg::REG_INPUT_LOW:    in_low_q   <= cfg_data_i;
        lrr_pkg::REG_INPUT_HIGH:   in_high_q  <= cfg_data_i;
        lrr_pkg::REG_OUTPUT_LOW:   out_low_q  <= cfg_data_i;
        lrr_pkg::REG_OUTPUT_HIGH:  out_high_q <= cfg_data_i;
        lrr_pkg::REG_LIMIT_ENABLE: lim_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Range terms derived from the registers, registered to keep the subtract and
  // absolute value out of the datapath. The user must change the configuration
  // only while idle (the block does not enforce it), so they settle before use.
  logic signed [lrr_pkg::DIFF_W-1:0] b_w, c_w;
  logic [lrr_pkg::WORD_W-1:0]        bm_d, cm_d;
  logic [lrr_pkg::WORD_W-1:0]        bm_q, cm_q, hm_q;
  logic                              bn_q, cn_q, czero_q, ascend_q;

  always_comb begin
    b_w  = lrr_pkg::DIFF_W'(out_high_q) - lrr_pkg::DIFF_W'(out_low_q);
    c_w  = lrr_pkg::DIFF_W'(in_high_q) - lrr_pkg::DIFF_W'(in_low_q);
    bm_d = b_w[lrr_pkg::DIFF_W-1] ? lrr_pkg::WORD_W'(-b_w) : lrr_pkg::WORD_W'(b_w);
    cm_d = c_w[lrr_pkg::DIFF_W-1] ? lrr_pkg::WORD_W'(-c_w) : lrr_pkg::WORD_W'(c_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bm_q     <= 32'd1000;
      bn_q     <= 1'b0;
      cm_q     <= 32'd1000;
      cn_q     <= 1'b0;
      hm_q     <= 32'd500;
      czero_q  <= 1'b0;
      ascend_q <= 1'b1;
    end else begin
      bm_q     <= bm_d;
      bn_q     <= b_w[lrr_pkg::DIFF_W-1];
      cm_q     <= cm_d;
      cn_q     <= c_w[lrr_pkg::DIFF_W-1];
      // The half-range offset has the sign of the divisor.
      hm_q     <= cm_d >> 1;
      czero_q  <= (c_w == '0);
      ascend_q <= (out_high_q > out_low_q);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. All stages move together whenever the skid register is
  // empty; the output register and skid register take up the item that
  // leaves the pipeline while the consumer stalls.
  // --------------------------------------------------------------------------
  logic           adv;
  logic [NST-1:0] v_q;
  logic           ov_q, sv_q, take;

  assign adv        = !sv_q;
  assign in_stall_o = sv_q;
  assign take       = ov_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: difference, magnitudes, product, rounded dividend.
  // --------------------------------------------------------------------------
  logic signed [lrr_pkg::WORD_W-1:0] x_q;
  logic signed [lrr_pkg::DIFF_W-1:0] a_q;
  logic [lrr_pkg::WORD_W-1:0]        am_q;
  logic                              an_q, anz_q;
  logic [lrr_pkg::PROD_W-1:0]        pm_q;
  logic                              pn_q;
  logic [lrr_pkg::DIVD_W-1:0]        dm_q, dm_d;
  logic                              dn_q, dn_d;
  logic [lrr_pkg::DIVD_W-1:0]        pm_ext, hm_ext;

  always_comb begin
    pm_ext = lrr_pkg::DIVD_W'(pm_q);
    hm_ext = lrr_pkg::DIVD_W'(hm_q);
    if (pn_q == cn_q) begin
      dm_d = pm_ext + hm_ext;
      dn_d = pn_q;
    end else if (pm_ext >= hm_ext) begin
      dm_d = pm_ext - hm_ext;
      dn_d = pn_q;
    end else begin
      dm_d = hm_ext - pm_ext;
      dn_d = cn_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q   <= sample_in_i;
      a_q   <= lrr_pkg::DIFF_W'(x_q) - lrr_pkg::DIFF_W'(in_low_q);
      am_q  <= a_q[lrr_pkg::DIFF_W-1] ? lrr_pkg::WORD_W'(-a_q) : lrr_pkg::WORD_W'(a_q);
      an_q  <= a_q[lrr_pkg::DIFF_W-1];
      anz_q <= (a_q != '0);
      pm_q  <= am_q * bm_q;
      pn_q  <= anz_q && (bm_q != '0) && (an_q != bn_q);
      dm_q  <= dm_d;
      dn_q  <= dn_d;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage. The upper dividend half
  // starts as the partial remainder; when it is not below the divisor the
  // quotient cannot fit and the item is flagged as overflowing.
  // --------------------------------------------------------------------------
  logic [lrr_pkg::WORD_W-1:0] dr_q  [lrr_pkg::DIV_STEPS];
  logic [lrr_pkg::QUOT_W-1:0] ds_q  [lrr_pkg::DIV_STEPS];
  logic                       ddn_q [lrr_pkg::DIV_STEPS];
  logic                       dov_q [lrr_pkg::DIV_STEPS];

  for (genvar k = 0; k < lrr_pkg::DIV_STEPS; k++) begin : g_div
    logic [lrr_pkg::WORD_W-1:0] r_in;
    logic [lrr_pkg::QUOT_W-1:0] s_in;
    logic                       dn_in, ov_in;
    logic [lrr_pkg::WORD_W:0]   t, t_sub;
    logic                       ge;

    if (k == 0) begin : g_first
      assign r_in  = dm_q[lrr_pkg::DIVD_W-1:lrr_pkg::QUOT_W];
      assign s_in  = dm_q[lrr_pkg::QUOT_W-1:0];
      assign dn_in = dn_q;
      assign ov_in = (dm_q[lrr_pkg::DIVD_W-1:lrr_pkg::QUOT_W] >= cm_q);
    end else begin : g_next
      assign r_in  = dr_q[k-1];
      assign s_in  = ds_q[k-1];
      assign dn_in = ddn_q[k-1];
      assign ov_in = dov_q[k-1];
    end

    always_comb begin
      t     = {r_in, s_in[lrr_pkg::QUOT_W-1]};
      t_sub = t - {1'b0, cm_q};
      ge    = (t >= {1'b0, cm_q});
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dr_q[k]  <= ge ? t_sub[lrr_pkg::WORD_W-1:0] : t[lrr_pkg::WORD_W-1:0];
        ds_q[k]  <= {s_in[lrr_pkg::QUOT_W-2:0], ge};
        ddn_q[k] <= dn_in;
        dov_q[k] <= ov_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sign restore and offset, then saturation and limiting.
  // --------------------------------------------------------------------------
  logic [lrr_pkg::QUOT_W-1:0]       q_w;
  logic                             qn_w;
  logic signed [lrr_pkg::SUM_W-1:0] qs_w;
  logic signed [lrr_pkg::SUM_W-1:0] y_q;
  logic                             ovf_y_q, qn_y_q;

  always_comb begin
    q_w  = ds_q[lrr_pkg::DIV_STEPS-1];
    qn_w = (q_w != '0) && (ddn_q[lrr_pkg::DIV_STEPS-1] != cn_q);
    qs_w = qn_w ? -lrr_pkg::SUM_W'(q_w) : lrr_pkg::SUM_W'(q_w);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q     <= lrr_pkg::SUM_W'(out_low_q) + qs_w;
      ovf_y_q <= dov_q[lrr_pkg::DIV_STEPS-1];
      qn_y_q  <= qn_w;
    end
  end

  lrr_pkg::result_t                res_d, res_q;
  logic signed [lrr_pkg::WORD_W-1:0] ysat, ylim;
  logic                              cl_sat, cl_lim;

  always_comb begin
    // Saturate to the signed DATA_WIDTH range first.
    cl_sat = 1'b1;
    if (ovf_y_q) begin
      ysat = qn_y_q ? lrr_pkg::SAT_MIN[lrr_pkg::WORD_W-1:0]
                    : lrr_pkg::SAT_MAX[lrr_pkg::WORD_W-1:0];
    end else if (y_q > lrr_pkg::SAT_MAX) begin
      ysat = lrr_pkg::SAT_MAX[lrr_pkg::WORD_W-1:0];
    end else if (y_q < lrr_pkg::SAT_MIN) begin
      ysat = lrr_pkg::SAT_MIN[lrr_pkg::WORD_W-1:0];
    end else begin
      ysat   = y_q[lrr_pkg::WORD_W-1:0];
      cl_sat = 1'b0;
    end

    // Limit to the output range, which may run either way.
    cl_lim = 1'b1;
    ylim   = ysat;
    if (!lim_en_q) begin
      cl_lim = 1'b0;
    end else if (ascend_q) begin
      if (ysat > out_high_q) begin
        ylim = out_high_q;
      end else if (ysat < out_low_q) begin
        ylim = out_low_q;
      end else begin
        cl_lim = 1'b0;
      end
    end else begin
      if (ysat < out_high_q) begin
        ylim = out_high_q;
      end else if (ysat > out_low_q) begin
        ylim = out_low_q;
      end else begin
        cl_lim = 1'b0;
      end
    end

    // An empty input range overrides the arithmetic.
    if (czero_q) begin
      res_d.mapped  = out_low_q;
      res_d.err     = 1'b1;
      res_d.clamped = 1'b0;
    end else begin
      res_d.mapped  = ylim;
      res_d.err     = 1'b0;
      res_d.clamped = cl_sat || cl_lim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid register.
  // --------------------------------------------------------------------------
  lrr_pkg::result_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (!sv_q) begin
      if (v_q[ST_R]) begin
        if (!ov_q || take) begin
          ov_q <= 1'b1;
        end else begin
          sv_q <= 1'b1;
        end
      end else if (take) begin
        ov_q <= 1'b0;
      end
    end else if (take) begin
      sv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!sv_q && v_q[ST_R] && (!ov_q || take)) begin
      out_q <= res_q;
    end else if (sv_q && take) begin
      out_q <= skid_q;
    end
    if (!sv_q && v_q[ST_R] && ov_q && !take) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o   = ov_q;
  assign mapped_out_o  = out_q.mapped;
  assign range_error_o = out_q.err;
  assign was_clamped_o = out_q.clamped;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LRR_ASSERT_NOW(a_stall_means_out_full, in_stall_o, out_valid_o, "input stalled with empty output")
  `LRR_ASSERT_NOW(a_skid_fill_on_stall, sv_q && !$past(sv_q), $past(out_valid_o && out_stall_i), "skid filled without a stalled output")
  `LRR_ASSERT_NEXT(a_overflow_clamps, v_q[ST_Y] && adv && ovf_y_q && !czero_q, res_q.clamped, "overflow not clamped")
  `LRR_ASSERT_NOW(a_error_not_clamped, out_valid_o && range_error_o, !was_clamped_o, "empty range result flagged as clamped")

endmodule

/* tb/tb_linear_range_remap.sv */
// ----------------------------------------------------------------------------
// Linear range remap testbench
// Drives samples and register writes into the remap block under random
// backpressure and idle gaps. Every returned result is checked against a
// scoreboard that predicts the rounded, saturated and limited mapping.
// ----------------------------------------------------------------------------
module tb_linear_range_remap;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths taken from the block's package.
  localparam int unsigned WORD_W     = lrr_pkg::WORD_W;
  localparam int unsigned CFG_IDX_W  = lrr_pkg::CFG_IDX_W;
  localparam int unsigned DATA_WIDTH = lrr_pkg::DATA_WIDTH;

  // The limit leaves a wide margin over the run at the slowest idling mix.
  localparam int unsigned LIMIT_CYCLES   = 400000;
  // These quiet cycles at the end outlast the pipeline, so they will expose
  // any result that shows up without a matching sample.
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned SETTING_GROUPS = 12;
  localparam int unsigned GROUP_ITEMS    = RANDOM_ITEMS / SETTING_GROUPS;

  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  // Highest index that maps to a real register; anything above is unused.
  localparam logic [CFG_IDX_W-1:0]     REG_LAST = lrr_pkg::REG_LIMIT_ENABLE;

  // Holds a copy of the register file and the queue of predicted results,
  // one per accepted sample, in acceptance order.
  class remap_scoreboard;
    longint           in_low;
    longint           in_high;
    longint           out_low;
    longint           out_high;
    bit               limit_on;
    lrr_pkg::result_t expected_maps[$];
    int unsigned      mismatches;

    function new();
      mismatches = 0;
      reset_regs();
    endfunction

    function void reset_regs();
      in_low   = 0;
      in_high  = 1000;
      out_low  = 0;
      out_high = 1000;
      limit_on = 1'b1;
    endfunction

    // Unused indexes fall through and leave the registers untouched.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        lrr_pkg::REG_INPUT_LOW:    in_low   = longint'($signed(data));
        lrr_pkg::REG_INPUT_HIGH:   in_high  = longint'($signed(data));
        lrr_pkg::REG_OUTPUT_LOW:   out_low  = longint'($signed(data));
        lrr_pkg::REG_OUTPUT_HIGH:  out_high = longint'($signed(data));
        lrr_pkg::REG_LIMIT_ENABLE: limit_on = data[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] magnitude_of(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // Sign and magnitude arithmetic keeps the 64-bit product exact; the
    // quotient is then restored to a signed value and offset by out_low.
    function lrr_pkg::result_t remap_sample(logic signed [WORD_W-1:0] x);
      longint           span_in;
      longint           span_out;
      longint           offs;
      longint           half;
      longint           sat_hi;
      longint           sat_lo;
      longint           y;
      logic [63:0]      prod_m;
      logic [63:0]      half_m;
      logic [63:0]      num_m;
      logic [63:0]      quot;
      bit               prod_n;
      bit               half_n;
      bit               num_n;
      bit               quot_n;
      lrr_pkg::result_t r;

      offs     = longint'(x) - in_low;
      span_out = out_high - out_low;
      span_in  = in_high - in_low;
      sat_hi   = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      sat_lo   = -sat_hi - 1;
      r.err     = 1'b0;
      r.clamped = 1'b0;

      if (span_in == 0) begin
        r.mapped = out_low[WORD_W-1:0];
        r.err    = 1'b1;
        return r;
      end

      half   = span_in / 2;
      half_m = magnitude_of(half);
      half_n = half < 0;
      prod_m = magnitude_of(offs) * magnitude_of(span_out);
      prod_n = (prod_m != 0) && ((offs < 0) != (span_out < 0));

      if (prod_n == half_n) begin
        num_m = prod_m + half_m;
        num_n = prod_n;
      end else if (prod_m >= half_m) begin
        num_m = prod_m - half_m;
        num_n = prod_n;
      end else begin
        num_m = half_m - prod_m;
        num_n = half_n;
      end

      quot   = num_m / magnitude_of(span_in);
      quot_n = (quot != 0) && (num_n != (span_in < 0));
      if (quot > (64'd1 << 40)) begin
        y = quot_n ? sat_lo - 1 : sat_hi + 1;
      end else begin
        y = (quot_n ? -longint'(quot) : longint'(quot)) + out_low;
      end

      if (y > sat_hi) begin
        y = sat_hi;
        r.clamped = 1'b1;
      end else if (y < sat_lo) begin
        y = sat_lo;
        r.clamped = 1'b1;
      end

      if (limit_on) begin
        if (out_high > out_low) begin
          if (y > out_high) begin
            y = out_high;
            r.clamped = 1'b1;
          end else if (y < out_low) begin
            y = out_low;
            r.clamped = 1'b1;
          end
        end else begin
          if (y < out_high) begin
            y = out_high;
            r.clamped = 1'b1;
          end else if (y > out_low) begin
            y = out_low;
            r.clamped = 1'b1;
          end
        end
      end

      r.mapped = y[WORD_W-1:0];
      return r;
    endfunction

    function void note_sample(logic signed [WORD_W-1:0] x);
      expected_maps.push_back(remap_sample(x));
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [WORD_W-1:0] mapped, logic err, logic clamped);
      lrr_pkg::result_t want;
      if (expected_maps.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  $signed(mapped)));
        return;
      end
      want = expected_maps.pop_front();
      if (mapped !== want.mapped)
        report_mismatch($sformatf("mapped_out %0d, expected %0d",
                                  $signed(mapped), $signed(want.mapped)));
      if (err !== want.err)
        report_mismatch($sformatf("range_error %b, expected %b", err, want.err));
      if (clamped !== want.clamped)
        report_mismatch($sformatf("was_clamped %b, expected %b", clamped, want.clamped));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [WORD_W-1:0]  sample_in_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [WORD_W-1:0]  mapped_out_o;
  logic                      range_error_o;
  logic                      was_clamped_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [WORD_W-1:0]         cfg_data_i;

  remap_scoreboard board;
  // Per-cycle chance, in percent, that the sender idles or the receiver stalls.
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     cycles = 0;

  linear_range_remap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .mapped_out_o  (mapped_out_o),
    .range_error_o (range_error_o),
    .was_clamped_o (was_clamped_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL linear_range_remap");
      $finish;
    end
  end

  // Result side. A transaction completes at an edge where valid is high and
  // our stall is low; both are sampled before this edge's updates land. The
  // stall for the next cycle is then drawn from the current receiver mix.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result(mapped_out_o, range_error_o, was_clamped_o);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // A word biased toward the edges of the 32-bit range and toward small
  // values, with plain random words for the rest.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(4))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return '0;
          3:       return '1;
          default: return 32'd1;
        endcase
      end
      1:       return 32'($urandom_range(2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // Most samples land inside the configured input range, some just past its
  // ends, and the rest anywhere in the 32-bit range.
  function automatic logic [WORD_W-1:0] pick_sample();
    longint      lo;
    longint      hi;
    longint      v;
    logic [63:0] span;
    if ($urandom_range(9) >= 7)
      return pick_word();
    lo   = (board.in_low < board.in_high) ? board.in_low : board.in_high;
    hi   = (board.in_low < board.in_high) ? board.in_high : board.in_low;
    span = 64'(hi - lo) + 64'd1;
    v    = lo + longint'({$urandom, $urandom} % span);
    if ($urandom_range(3) == 0)
      v += longint'($urandom_range(8)) - 4;
    if (v > WORD_MAX)
      v = WORD_MAX;
    if (v < WORD_MIN)
      v = WORD_MIN;
    return v[WORD_W-1:0];
  endfunction

  // Offers one sample after a random number of idle cycles and returns at
  // the edge that accepts it. Valid stays high between back-to-back samples,
  // so it is never lowered and raised within the same time step.
  task automatic send_sample(input logic [WORD_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= x;
    do @(posedge clk_i); while (in_stall_o);
    board.note_sample(x);
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.expected_maps.size() != 0)
      @(posedge clk_i);
  endtask

  // One register write transaction; the caller lowers valid after the last.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [WORD_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  // Rewrites the whole register file once the pipeline is empty. The upper
  // bits of the limit enable word are random, since only bit 0 counts. A
  // write to an unused index can be added; it must change nothing.
  task automatic apply_settings(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
                                input logic [WORD_W-1:0] olo, input logic [WORD_W-1:0] ohi,
                                input bit lim, input bit poke_unused);
    wait_drained();
    write_reg(lrr_pkg::REG_INPUT_LOW, lo);
    write_reg(lrr_pkg::REG_INPUT_HIGH, hi);
    write_reg(lrr_pkg::REG_OUTPUT_LOW, olo);
    write_reg(lrr_pkg::REG_OUTPUT_HIGH, ohi);
    write_reg(lrr_pkg::REG_LIMIT_ENABLE, ($urandom & ~32'd1) | 32'(lim));
    if (poke_unused)
      write_reg(CFG_IDX_W'($urandom_range(int'(REG_LAST) + 1, 2 ** CFG_IDX_W - 1)), $urandom);
    cfg_valid_i <= 1'b0;
    // The block derives its range terms in the cycle after a write, so give
    // it a short quiet spell before the next sample.
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] olo;
    logic [WORD_W-1:0] ohi;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    sample_in_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    board       = new();

    send_idle_pct  = 26;
    recv_stall_pct = 81;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings map 0..1000 onto itself with limiting on: both ends,
    // the rounding midpoint, just outside each end, and the word extremes.
    send_sample(32'd0);
    send_sample(32'd1000);
    send_sample(32'd499);
    send_sample(32'd500);
    send_sample('1);
    send_sample(32'd1001);
    send_sample(WORD_MAX);
    send_sample(WORD_MIN);

    // Empty input range: every sample returns output_low with the error set.
    apply_settings(32'd7, 32'd7, -32'sd12345, 32'd99, 1'b1, 1'b0);
    send_sample(32'd7);
    send_sample(32'd0);
    send_sample(WORD_MIN);

    // Unit input span onto the full output span, limiting off: the quotient
    // runs far past 32 bits and must saturate both ways.
    apply_settings(32'd0, 32'd1, WORD_MIN, WORD_MAX, 1'b0, 1'b0);
    send_sample(WORD_MAX);
    send_sample(WORD_MIN);
    send_sample(32'd0);
    send_sample(32'd1);

    // Reversed input range and descending output range, limiting on.
    apply_settings(32'd100, -32'sd100, 32'd50, -32'sd50, 1'b1, 1'b0);
    send_sample(32'd200);
    send_sample(-32'sd200);
    send_sample(32'd0);
    send_sample(32'd37);

    // Flat output range over the widest input range: always output_low.
    apply_settings(WORD_MIN, WORD_MAX, 32'd5, 32'd5, 1'b1, 1'b0);
    send_sample(WORD_MAX);
    send_sample(WORD_MIN);
    send_sample(32'd0);

    // Writes to unused indexes must leave the settings alone.
    apply_settings(-32'sd1000, 32'd1000, 32'd0, 32'd255, 1'b1, 1'b1);
    send_sample(32'd1);

    // Random part: the item budget is split into groups, each with its own
    // settings. The first third idles the sender lightly and stalls the
    // receiver hard, the second swaps the two, the last runs flat out.
    for (int unsigned g = 0; g < SETTING_GROUPS; g++) begin
      case (g / (SETTING_GROUPS / 3))
        0: begin
          send_idle_pct  = 26;
          recv_stall_pct = 81;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 26;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase

      if (g == 0) begin
        lo  = WORD_MIN;
        hi  = WORD_MAX;
        olo = WORD_MIN;
        ohi = WORD_MAX;
      end else if (g == SETTING_GROUPS - 1) begin
        lo  = WORD_MAX;
        hi  = WORD_MIN;
        olo = WORD_MAX;
        ohi = WORD_MIN;
      end else begin
        lo  = pick_word();
        hi  = ($urandom_range(7) == 0) ? lo : pick_word();
        olo = pick_word();
        ohi = ($urandom_range(9) == 0) ? olo : pick_word();
      end
      apply_settings(lo, hi, olo, ohi, 1'($urandom_range(1)), $urandom_range(3) == 0);

      for (int unsigned i = 0; i < GROUP_ITEMS; i++) begin
        // Now and then the sender stops mid-group until the pipe is empty.
        if (i == GROUP_ITEMS / 2 && (g % 3) == 1)
          wait_drained();
        send_sample(pick_sample());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.expected_maps.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.expected_maps.size()));

    if (board.mismatches == 0) begin
      $display("PASS linear_range_remap");
    end else begin
      $display("FAIL linear_range_remap");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lrr_pkg.sv
rtl/linear_range_remap.sv
tb/tb_linear_range_remap.sv
